FILE: hw/rtl/tf_pkg.sv
package tf_pkg;

    // cipher geometry
    localparam int WORD_W         = 32;
    localparam int ROUNDS         = 16;
    localparam int ROUND_W        = $clog2(ROUNDS);
    localparam int SBOX_DEPTH     = 256;
    localparam int TABLE_COUNT    = 4;
    localparam int SUBKEY_COUNT   = 40;
    localparam int KEY_AW         = $clog2(SUBKEY_COUNT);

    // subkey layout: whitening words low and high, then round key pairs
    localparam int WHITEN_LO      = 0;
    localparam int WHITEN_HI      = 4;
    localparam int KEY_ROUND_BASE = 8;

    typedef logic [KEY_AW-1:0] tf_key_addr_t;

    typedef enum logic [1:0] {
        OP_LOAD_SBOX = 2'd0,
        OP_LOAD_KEY  = 2'd1,
        OP_ENCRYPT   = 2'd2,
        OP_DECRYPT   = 2'd3
    } tf_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN0,
        ST_WIN1,
        ST_WIN2,
        ST_RND_A,
        ST_RND_B,
        ST_WOUT0,
        ST_WOUT1,
        ST_WOUT2,
        ST_DONE
    } tf_state_t;

    // address of a whitening word: base plus word number
    function automatic tf_key_addr_t whiten_addr(input int base, input logic [1:0] idx);
        return tf_key_addr_t'(base) + tf_key_addr_t'(idx);
    endfunction

    // address of the even round key of round kr
    function automatic tf_key_addr_t round_key_addr(input logic [ROUND_W-1:0] kr);
        return tf_key_addr_t'(KEY_ROUND_BASE) + tf_key_addr_t'({kr, 1'b0});
    endfunction

    function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
        return {v[WORD_W-2:0], v[WORD_W-1]};
    endfunction

    function automatic logic [WORD_W-1:0] rotr1(input logic [WORD_W-1:0] v);
        return {v[0], v[WORD_W-1:1]};
    endfunction

endpackage

FILE: hw/rtl/tf_if.sv
// command channel: loads and block items
interface tf_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [1:0]                table_select;
    logic [7:0]                entry_index;
    logic [tf_pkg::WORD_W-1:0] load_value;
    logic [tf_pkg::WORD_W-1:0] block_word0;
    logic [tf_pkg::WORD_W-1:0] block_word1;
    logic [tf_pkg::WORD_W-1:0] block_word2;
    logic [tf_pkg::WORD_W-1:0] block_word3;

    modport source (
        output valid, opcode, table_select, entry_index, load_value,
               block_word0, block_word1, block_word2, block_word3,
        input  ready
    );
    modport sink (
        input  valid, opcode, table_select, entry_index, load_value,
               block_word0, block_word1, block_word2, block_word3,
        output ready
    );
endinterface

// result channel: one item per encrypt or decrypt
interface tf_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [tf_pkg::WORD_W-1:0] result_word0;
    logic [tf_pkg::WORD_W-1:0] result_word1;
    logic [tf_pkg::WORD_W-1:0] result_word2;
    logic [tf_pkg::WORD_W-1:0] result_word3;

    modport source (
        output valid, result_word0, result_word1, result_word2, result_word3,
        input  ready
    );
    modport sink (
        input  valid, result_word0, result_word1, result_word2, result_word3,
        output ready
    );
endinterface

FILE: hw/rtl/tf_ram.sv
// one write port, two registered read ports
module tf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hw/rtl/twofish_block_cipher_core_top.sv
// channel | interface     | moves
// --------+---------------+-------------------------------------------------
// cmd     | tf_cmd_if     | load sbox word, load subkey, encrypt, decrypt
// rsp     | tf_rsp_if     | four result words per encrypt or decrypt item
//
// a load item writes one table word, or one subkey word when its index is below SUBKEY_COUNT.
// a block item runs through input whitening (WIN0..WIN2), then each round in RND_A and RND_B
// (registered reads of the four dual-port sbox memories, then the g xor and pht), output
// whitening (WOUT0..WOUT2), DONE to hand the result over, and idle to take the next item;
// no new item is taken before the last one is through.
// reset clears the control state only; the memories hold nothing until loaded.
// a result held on rsp stalls the core in its last state; cmd is taken only in idle.
module twofish_block_cipher_core_top (
    input  logic     clk,
    input  logic     rst_n,
    tf_cmd_if.sink   cmd,
    tf_rsp_if.source rsp
);

    localparam int W = tf_pkg::WORD_W;

    tf_pkg::tf_state_t state_reg, state_next;
    logic [tf_pkg::ROUND_W-1:0] round_reg, round_next;
    logic                       decrypt_reg, decrypt_next;
    logic [3:0][W-1:0]          w_reg, w_next;
    logic [3:0][W-1:0]          res_reg, res_next;
    logic                       res_valid_reg, res_valid_next;

    tf_pkg::tf_op_t      op;
    logic                cmd_fire;
    logic                block_fire;
    logic                last_round;
    logic                out_free;
    logic                sbox_we;
    logic                key_we;
    logic [tf_pkg::ROUND_W-1:0] key_round;
    tf_pkg::tf_key_addr_t key_ra_a, key_ra_b;
    logic [W-1:0]        key_rd_a, key_rd_b;
    logic [W-1:0]        sbox_rd_a [tf_pkg::TABLE_COUNT];
    logic [W-1:0]        sbox_rd_b [tf_pkg::TABLE_COUNT];
    logic [W-1:0]        w1_rot;
    logic [W-1:0]        t0, t1, f0, f1, n2, n3;

    // handshake decode
    assign cmd.ready  = state_reg == tf_pkg::ST_IDLE;
    assign op         = tf_pkg::tf_op_t'(cmd.opcode);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign block_fire = cmd_fire && (op == tf_pkg::OP_ENCRYPT || op == tf_pkg::OP_DECRYPT);
    assign last_round = round_reg == tf_pkg::ROUND_W'(tf_pkg::ROUNDS - 1);
    assign out_free   = !res_valid_reg || rsp.ready;
    assign key_round  = decrypt_reg ? tf_pkg::ROUND_W'(tf_pkg::ROUNDS - 1) - round_reg
                                    : round_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tf_pkg::ST_IDLE:
            begin
                if (block_fire)
                begin
                    state_next = tf_pkg::ST_WIN0;
                end
            end
            tf_pkg::ST_WIN0:  state_next = tf_pkg::ST_WIN1;
            tf_pkg::ST_WIN1:  state_next = tf_pkg::ST_WIN2;
            tf_pkg::ST_WIN2:  state_next = tf_pkg::ST_RND_A;
            tf_pkg::ST_RND_A: state_next = tf_pkg::ST_RND_B;
            tf_pkg::ST_RND_B:
            begin
                state_next = last_round ? tf_pkg::ST_WOUT0 : tf_pkg::ST_RND_A;
            end
            tf_pkg::ST_WOUT0: state_next = tf_pkg::ST_WOUT1;
            tf_pkg::ST_WOUT1: state_next = tf_pkg::ST_WOUT2;
            tf_pkg::ST_WOUT2: state_next = tf_pkg::ST_DONE;
            tf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tf_pkg::ST_IDLE;
                end
            end
            default:          state_next = tf_pkg::ST_IDLE;
        endcase
    end

    // state outputs: memory writes, subkey read addresses
    always_comb
    begin
        sbox_we   = cmd_fire && op == tf_pkg::OP_LOAD_SBOX;
        key_we    = cmd_fire && op == tf_pkg::OP_LOAD_KEY
                    && cmd.entry_index < 8'(tf_pkg::SUBKEY_COUNT);
        key_ra_a  = '0;
        key_ra_b  = '0;
        unique case (state_reg)
            tf_pkg::ST_WIN0:
            begin
                key_ra_a = tf_pkg::whiten_addr(decrypt_reg ? tf_pkg::WHITEN_HI
                                                           : tf_pkg::WHITEN_LO, 2'd0);
                key_ra_b = tf_pkg::whiten_addr(decrypt_reg ? tf_pkg::WHITEN_HI
                                                           : tf_pkg::WHITEN_LO, 2'd1);
            end
            tf_pkg::ST_WIN1:
            begin
                key_ra_a = tf_pkg::whiten_addr(decrypt_reg ? tf_pkg::WHITEN_HI
                                                           : tf_pkg::WHITEN_LO, 2'd2);
                key_ra_b = tf_pkg::whiten_addr(decrypt_reg ? tf_pkg::WHITEN_HI
                                                           : tf_pkg::WHITEN_LO, 2'd3);
            end
            tf_pkg::ST_RND_A:
            begin
                key_ra_a = tf_pkg::round_key_addr(key_round);
                key_ra_b = tf_pkg::round_key_addr(key_round) + tf_pkg::tf_key_addr_t'(1);
            end
            tf_pkg::ST_WOUT0:
            begin
                key_ra_a = tf_pkg::whiten_addr(decrypt_reg ? tf_pkg::WHITEN_LO
                                                           : tf_pkg::WHITEN_HI, 2'd0);
                key_ra_b = tf_pkg::whiten_addr(decrypt_reg ? tf_pkg::WHITEN_LO
                                                           : tf_pkg::WHITEN_HI, 2'd1);
            end
            tf_pkg::ST_WOUT1:
            begin
                key_ra_a = tf_pkg::whiten_addr(decrypt_reg ? tf_pkg::WHITEN_LO
                                                           : tf_pkg::WHITEN_HI, 2'd2);
                key_ra_b = tf_pkg::whiten_addr(decrypt_reg ? tf_pkg::WHITEN_LO
                                                           : tf_pkg::WHITEN_HI, 2'd3);
            end
            tf_pkg::ST_IDLE, tf_pkg::ST_WIN2, tf_pkg::ST_RND_B,
            tf_pkg::ST_WOUT2, tf_pkg::ST_DONE:
            begin
                key_ra_a = '0;
                key_ra_b = '0;
            end
            default:
            begin
                key_ra_a = '0;
                key_ra_b = '0;
            end
        endcase
    end

    // subkey memory
    tf_ram #(
        .WIDTH (W),
        .DEPTH (tf_pkg::SUBKEY_COUNT)
    ) u_key_ram (
        .clk     (clk),
        .we      (key_we),
        .waddr   (cmd.entry_index[tf_pkg::KEY_AW-1:0]),
        .wdata   (cmd.load_value),
        .raddr_a (key_ra_a),
        .raddr_b (key_ra_b),
        .rdata_a (key_rd_a),
        .rdata_b (key_rd_b)
    );

    // four sbox tables; port a serves g(w0), port b serves g(rotl(w1, 8))
    assign w1_rot = {w_reg[1][W-9:0], w_reg[1][W-1:W-8]};

    for (genvar t = 0; t < tf_pkg::TABLE_COUNT; t++)
    begin : g_sbox
        tf_ram #(
            .WIDTH (W),
            .DEPTH (tf_pkg::SBOX_DEPTH)
        ) u_sbox_ram (
            .clk     (clk),
            .we      (sbox_we && cmd.table_select == 2'(t)),
            .waddr   (cmd.entry_index),
            .wdata   (cmd.load_value),
            .raddr_a (w_reg[0][8*t +: 8]),
            .raddr_b (w1_rot[8*t +: 8]),
            .rdata_a (sbox_rd_a[t]),
            .rdata_b (sbox_rd_b[t])
        );
    end

    // g outputs and pht with the round keys
    always_comb
    begin
        t0 = '0;
        t1 = '0;
        for (int t = 0; t < tf_pkg::TABLE_COUNT; t++)
        begin
            t0 = t0 ^ sbox_rd_a[t];
            t1 = t1 ^ sbox_rd_b[t];
        end
    end

    assign f0 = t0 + t1 + key_rd_a;
    assign f1 = t0 + {t1[W-2:0], 1'b0} + key_rd_b;
    assign n2 = decrypt_reg ? (tf_pkg::rotl1(w_reg[2]) ^ f0) : tf_pkg::rotr1(w_reg[2] ^ f0);
    assign n3 = decrypt_reg ? tf_pkg::rotr1(w_reg[3] ^ f1) : (tf_pkg::rotl1(w_reg[3]) ^ f1);

    // block words, round counter and result register
    always_comb
    begin
        w_next         = w_reg;
        round_next     = round_reg;
        decrypt_next   = decrypt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !rsp.ready;
        unique case (state_reg)
            tf_pkg::ST_IDLE:
            begin
                if (block_fire)
                begin
                    w_next[0]    = cmd.block_word0;
                    w_next[1]    = cmd.block_word1;
                    w_next[2]    = cmd.block_word2;
                    w_next[3]    = cmd.block_word3;
                    round_next   = '0;
                    decrypt_next = op == tf_pkg::OP_DECRYPT;
                end
            end
            tf_pkg::ST_WIN1, tf_pkg::ST_WOUT1:
            begin
                w_next[0] = w_reg[0] ^ key_rd_a;
                w_next[1] = w_reg[1] ^ key_rd_b;
            end
            tf_pkg::ST_WIN2, tf_pkg::ST_WOUT2:
            begin
                w_next[2] = w_reg[2] ^ key_rd_a;
                w_next[3] = w_reg[3] ^ key_rd_b;
            end
            tf_pkg::ST_RND_B:
            begin
                // halves swap after every round but the last
                if (last_round)
                begin
                    w_next[2] = n2;
                    w_next[3] = n3;
                end
                else
                begin
                    w_next[0] = n2;
                    w_next[1] = n3;
                    w_next[2] = w_reg[0];
                    w_next[3] = w_reg[1];
                end
                round_next = round_reg + tf_pkg::ROUND_W'(1);
            end
            tf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res_next       = w_reg;
                    res_valid_next = 1'b1;
                end
            end
            tf_pkg::ST_WIN0, tf_pkg::ST_RND_A, tf_pkg::ST_WOUT0:
            begin
                w_next = w_reg;
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tf_pkg::ST_IDLE;
            round_reg     <= '0;
            decrypt_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            decrypt_reg   <= decrypt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        res_reg <= res_next;
    end

    // result channel
    assign rsp.valid        = res_valid_reg;
    assign rsp.result_word0 = res_reg[0];
    assign rsp.result_word1 = res_reg[1];
    assign rsp.result_word2 = res_reg[2];
    assign rsp.result_word3 = res_reg[3];

    // a block item always starts with input whitening
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        block_fire |=> state_reg == tf_pkg::ST_WIN0)
        else $error("block item did not start whitening");

    // round counter never passes the last round
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= tf_pkg::ROUND_W'(tf_pkg::ROUNDS - 1))
        else $error("round counter out of range");

    // a new result only comes out of the final state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_next && !res_valid_reg) |-> state_reg == tf_pkg::ST_DONE)
        else $error("result raised outside the final state");

    // key material never changes while a block is in flight
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != tf_pkg::ST_IDLE |-> !sbox_we && !key_we)
        else $error("memory write during block processing");

endmodule

FILE: sim/twofish_block_cipher_core_top_tb.sv
module twofish_block_cipher_core_top_tb;
    import tf_pkg::*;

    // four block words, word0 in the low 32 bits
    typedef logic [3:0][WORD_W-1:0] quad_t;

    typedef struct packed {
        tf_op_t            op;
        logic [1:0]        tsel;
        logic [7:0]        idx;
        logic [WORD_W-1:0] val;
        quad_t             blk;
    } cmd_item_t;

    typedef struct packed {
        cmd_item_t cmd;
        bit        typed;
        quad_t     want;
    } dir_row_t;

    localparam int    RANDOM_ITEMS = 870;
    localparam int    DRAIN_CYCLES = 2 * ROUNDS + 16;
    localparam int    CYCLE_LIMIT  = 1000000;
    localparam int    LONG_HOLD    = 600;
    localparam quad_t ZERO_Q = '0;
    localparam quad_t ONES_Q = '1;
    localparam quad_t PAT_Q  = {32'hfedcba98, 32'h76543210, 32'h89abcdef, 32'h01234567};
    localparam quad_t HIGH_Q = {4{32'h80808080}};
    localparam quad_t JUNK_Q = {4{32'h5a5aa5a5}};

    // directed part, run with entries 0 and 255 of every table and every subkey at zero
    localparam int DIR_ROWS = 22;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // zero key material: rotations of all-zero and all-one words are fixed points
        '{'{OP_ENCRYPT,   2'd0, 8'd0,   32'h0000_0000, ZERO_Q}, 1'b1, ZERO_Q},
        '{'{OP_DECRYPT,   2'd3, 8'd255, 32'hffff_ffff, ZERO_Q}, 1'b1, ZERO_Q},
        '{'{OP_ENCRYPT,   2'd3, 8'd255, 32'hffff_ffff, ONES_Q}, 1'b1, ONES_Q},
        '{'{OP_DECRYPT,   2'd0, 8'd0,   32'h0000_0000, ONES_Q}, 1'b1, ONES_Q},
        // subkey loads past the end are dropped
        '{'{OP_LOAD_KEY,  2'd0, 8'd40,  32'hffff_ffff, ONES_Q}, 1'b0, ZERO_Q},
        '{'{OP_LOAD_KEY,  2'd3, 8'd255, 32'hffff_ffff, ONES_Q}, 1'b0, ZERO_Q},
        '{'{OP_ENCRYPT,   2'd0, 8'd0,   32'h0000_0000, ONES_Q}, 1'b1, ONES_Q},
        // table extremes
        '{'{OP_LOAD_SBOX, 2'd3, 8'd255, 32'hffff_ffff, JUNK_Q}, 1'b0, ZERO_Q},
        '{'{OP_LOAD_SBOX, 2'd0, 8'd0,   32'h8000_0001, JUNK_Q}, 1'b0, ZERO_Q},
        '{'{OP_ENCRYPT,   2'd0, 8'd0,   32'h0000_0000, ONES_Q}, 1'b0, ZERO_Q},
        '{'{OP_DECRYPT,   2'd0, 8'd0,   32'h0000_0000, ONES_Q}, 1'b0, ZERO_Q},
        // whitening and last round key
        '{'{OP_LOAD_KEY,  2'd0, 8'd0,   32'hffff_ffff, JUNK_Q}, 1'b0, ZERO_Q},
        '{'{OP_LOAD_KEY,  2'd0, 8'd39,  32'ha5a5_a5a5, JUNK_Q}, 1'b0, ZERO_Q},
        '{'{OP_LOAD_KEY,  2'd0, 8'd7,   32'h1234_5678, JUNK_Q}, 1'b0, ZERO_Q},
        '{'{OP_ENCRYPT,   2'd0, 8'd0,   32'h0000_0000, ZERO_Q}, 1'b0, ZERO_Q},
        '{'{OP_DECRYPT,   2'd0, 8'd0,   32'h0000_0000, ZERO_Q}, 1'b0, ZERO_Q},
        '{'{OP_ENCRYPT,   2'd0, 8'd0,   32'h0000_0000, PAT_Q},  1'b0, ZERO_Q},
        '{'{OP_DECRYPT,   2'd0, 8'd0,   32'h0000_0000, PAT_Q},  1'b0, ZERO_Q},
        // middle tables
        '{'{OP_LOAD_SBOX, 2'd1, 8'd128, 32'h5a5a_5a5a, ZERO_Q}, 1'b0, ZERO_Q},
        '{'{OP_LOAD_SBOX, 2'd2, 8'd1,   32'hdead_beef, ZERO_Q}, 1'b0, ZERO_Q},
        '{'{OP_ENCRYPT,   2'd0, 8'd0,   32'h0000_0000, HIGH_Q}, 1'b0, ZERO_Q},
        '{'{OP_DECRYPT,   2'd0, 8'd0,   32'h0000_0000, HIGH_Q}, 1'b0, ZERO_Q}
    };

    logic clk;
    logic rst_n;

    tf_cmd_if cmd_ch ();
    tf_rsp_if rsp_ch ();

    twofish_block_cipher_core_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // predictor state
    logic [WORD_W-1:0] sbox_mem [TABLE_COUNT * SBOX_DEPTH];
    logic [WORD_W-1:0] subkeys [SUBKEY_COUNT];
    quad_t             expected_blocks [$];
    quad_t             last_out;

    int    error_count;
    int    results_seen;
    int    enc_sent;
    int    dec_sent;
    int    loads_sent;
    int    burst_left;
    int    cycle_count;
    int    hold_left;
    int    holds_taken;
    int    rx_mode;
    int    mode_left;
    quad_t got_blk;
    quad_t want_blk;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [WORD_W-1:0] rot_l(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] rot_r(input logic [WORD_W-1:0] v, input int n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    // xor of one table word per byte of x
    function automatic logic [WORD_W-1:0] g_mix(input logic [WORD_W-1:0] x);
        return sbox_mem[{2'd0, x[7:0]}] ^ sbox_mem[{2'd1, x[15:8]}]
             ^ sbox_mem[{2'd2, x[23:16]}] ^ sbox_mem[{2'd3, x[31:24]}];
    endfunction

    // round function outputs {f1, f0}: g lookups then pht with the round keys
    function automatic logic [2*WORD_W-1:0] feistel_f(input logic [WORD_W-1:0] a,
                                                     input logic [WORD_W-1:0] b,
                                                     input int r);
        logic [WORD_W-1:0] t0;
        logic [WORD_W-1:0] t1;
        logic [WORD_W-1:0] f0;
        logic [WORD_W-1:0] f1;
        t0 = g_mix(a);
        t1 = g_mix(rot_l(b, 8));
        f0 = t0 + t1 + subkeys[KEY_ROUND_BASE + 2 * r];
        f1 = t0 + (t1 << 1) + subkeys[KEY_ROUND_BASE + 2 * r + 1];
        return {f1, f0};
    endfunction

    function automatic quad_t encipher_block(input quad_t blk);
        logic [WORD_W-1:0]   w [4];
        logic [WORD_W-1:0]   t;
        logic [2*WORD_W-1:0] f;
        for (int i = 0; i < 4; i++)
            w[i] = blk[i] ^ subkeys[WHITEN_LO + i];
        for (int r = 0; r < ROUNDS; r++)
        begin
            f    = feistel_f(w[0], w[1], r);
            w[2] = rot_r(w[2] ^ f[WORD_W-1:0], 1);
            w[3] = rot_l(w[3], 1) ^ f[2*WORD_W-1:WORD_W];
            t = w[0]; w[0] = w[2]; w[2] = t;
            t = w[1]; w[1] = w[3]; w[3] = t;
        end
        return {w[1] ^ subkeys[WHITEN_HI + 3], w[0] ^ subkeys[WHITEN_HI + 2],
                w[3] ^ subkeys[WHITEN_HI + 1], w[2] ^ subkeys[WHITEN_HI]};
    endfunction

    function automatic quad_t decipher_block(input quad_t blk);
        logic [WORD_W-1:0]   w [4];
        logic [WORD_W-1:0]   t;
        logic [2*WORD_W-1:0] f;
        w[2] = blk[0] ^ subkeys[WHITEN_HI];
        w[3] = blk[1] ^ subkeys[WHITEN_HI + 1];
        w[0] = blk[2] ^ subkeys[WHITEN_HI + 2];
        w[1] = blk[3] ^ subkeys[WHITEN_HI + 3];
        for (int r = ROUNDS - 1; r >= 0; r--)
        begin
            t = w[0]; w[0] = w[2]; w[2] = t;
            t = w[1]; w[1] = w[3]; w[3] = t;
            f    = feistel_f(w[0], w[1], r);
            w[2] = rot_l(w[2], 1) ^ f[WORD_W-1:0];
            w[3] = rot_r(w[3] ^ f[2*WORD_W-1:WORD_W], 1);
        end
        return {w[3] ^ subkeys[WHITEN_LO + 3], w[2] ^ subkeys[WHITEN_LO + 2],
                w[1] ^ subkeys[WHITEN_LO + 1], w[0] ^ subkeys[WHITEN_LO]};
    endfunction

    // update the key material or compute a block; returns 1 when a result follows
    function automatic bit cipher_step(input cmd_item_t it, output quad_t res);
        res = '0;
        case (it.op)
            OP_LOAD_SBOX:
            begin
                sbox_mem[{it.tsel, it.idx}] = it.val;
                return 1'b0;
            end
            OP_LOAD_KEY:
            begin
                if (it.idx < SUBKEY_COUNT)
                    subkeys[it.idx] = it.val;
                return 1'b0;
            end
            OP_ENCRYPT:
            begin
                res = encipher_block(it.blk);
                return 1'b1;
            end
            default:
            begin
                res = decipher_block(it.blk);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(0, 19))
                0:       q[i] = '0;
                1:       q[i] = '1;
                default: q[i] = $urandom;
            endcase
        end
        return q;
    endfunction

    // mostly block items, many of them decrypting the previous result
    function automatic cmd_item_t random_item();
        cmd_item_t it;
        int        pick;
        pick    = $urandom_range(0, 99);
        it.tsel = 2'($urandom_range(0, 3));
        it.idx  = 8'($urandom_range(0, 255));
        it.val  = $urandom;
        it.blk  = random_quad();
        if (pick < 8)
            it.op = OP_LOAD_SBOX;
        else if (pick < 13)
        begin
            it.op = OP_LOAD_KEY;
            if ($urandom_range(0, 3) != 0)
                it.idx = 8'($urandom_range(0, SUBKEY_COUNT + 7));
        end
        else if (pick < 55)
            it.op = OP_ENCRYPT;
        else if (pick < 80)
        begin
            it.op  = OP_DECRYPT;
            it.blk = last_out;
        end
        else
            it.op = OP_DECRYPT;
        return it;
    endfunction

    // offer one item in the current burst, wait for accept, then predict
    task automatic send_item(input cmd_item_t it, input bit typed, input quad_t want);
        quad_t res;
        int    gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= it.op;
        cmd_ch.table_select <= it.tsel;
        cmd_ch.entry_index  <= it.idx;
        cmd_ch.load_value   <= it.val;
        cmd_ch.block_word0  <= it.blk[0];
        cmd_ch.block_word1  <= it.blk[1];
        cmd_ch.block_word2  <= it.blk[2];
        cmd_ch.block_word3  <= it.blk[3];
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (cipher_step(it, res))
        begin
            expected_blocks.push_back(typed ? want : res);
            last_out = res;
        end
        case (it.op)
            OP_ENCRYPT: enc_sent++;
            OP_DECRYPT: dec_sent++;
            default:    loads_sent++;
        endcase
    endtask

    // write every table word and every subkey, zero or random
    task automatic fill_store(input bit rand_fill);
        cmd_item_t it;
        for (int e = 0; e < TABLE_COUNT * SBOX_DEPTH + SUBKEY_COUNT; e++)
        begin
            it.blk = random_quad();
            it.val = rand_fill ? $urandom : '0;
            if (e < TABLE_COUNT * SBOX_DEPTH)
            begin
                it.op   = OP_LOAD_SBOX;
                it.tsel = 2'(e / SBOX_DEPTH);
                it.idx  = 8'(e % SBOX_DEPTH);
            end
            else
            begin
                it.op   = OP_LOAD_KEY;
                it.tsel = 2'($urandom_range(0, 3));
                it.idx  = 8'(e - TABLE_COUNT * SBOX_DEPTH);
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // zero entries 0 and 255 of every table and every subkey
    task automatic clear_outer_entries();
        cmd_item_t it;
        for (int e = 0; e < 2 * TABLE_COUNT + SUBKEY_COUNT; e++)
        begin
            it.blk = random_quad();
            it.val = '0;
            if (e < 2 * TABLE_COUNT)
            begin
                it.op   = OP_LOAD_SBOX;
                it.tsel = 2'(e / 2);
                it.idx  = (e % 2 == 0) ? 8'd0 : 8'd255;
            end
            else
            begin
                it.op   = OP_LOAD_KEY;
                it.tsel = 2'($urandom_range(0, 3));
                it.idx  = 8'(e - 2 * TABLE_COUNT);
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // stimulus
    initial
    begin
        cmd_ch.valid        = 1'b0;
        cmd_ch.opcode       = OP_LOAD_SBOX;
        cmd_ch.table_select = '0;
        cmd_ch.entry_index  = '0;
        cmd_ch.load_value   = '0;
        cmd_ch.block_word0  = '0;
        cmd_ch.block_word1  = '0;
        cmd_ch.block_word2  = '0;
        cmd_ch.block_word3  = '0;
        burst_left          = 0;
        last_out            = '0;
        rst_n               = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fill_store(1'b1);
        clear_outer_entries();
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TABLE[i].cmd, DIR_TABLE[i].typed, DIR_TABLE[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_item(random_item(), 1'b0, '0);
        cmd_ch.valid <= 1'b0;

        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d encrypt and %0d decrypt items, %0d key material loads",
                 enc_sent, dec_sent, loads_sent);
        $display("%0d results checked, %0d long output stalls, %0d mismatches",
                 results_seen, holds_taken, error_count);
        if (error_count == 0 && expected_blocks.size() == 0)
            $display("twofish_block_cipher_core_top_tb passed");
        else
            $display("twofish_block_cipher_core_top_tb failed");
        $finish;
    end

    // output stalls: changing patterns, plus two long hold-offs to back up the input
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left    = 0;
        holds_taken  = 0;
        rx_mode      = 0;
        mode_left    = 0;
    end

    always @(posedge clk)
    begin
        if (holds_taken < 2 && results_seen >= 100 + 300 * holds_taken)
        begin
            hold_left = LONG_HOLD;
            holds_taken++;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            case (rx_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= cycle_count[2];
            endcase
        end
    end

    // result checking against the oldest expectation
    initial
    begin
        error_count  = 0;
        results_seen = 0;
        enc_sent     = 0;
        dec_sent     = 0;
        loads_sent   = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            got_blk = {rsp_ch.result_word3, rsp_ch.result_word2,
                       rsp_ch.result_word1, rsp_ch.result_word0};
            if (expected_blocks.size() == 0)
            begin
                $error("result item with nothing expected: %h", got_blk);
                error_count++;
            end
            else
            begin
                want_blk = expected_blocks.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (got_blk[i] !== want_blk[i])
                    begin
                        $error("result_word%0d: expected %h, actual %h",
                               i, want_blk[i], got_blk[i]);
                        error_count++;
                    end
                end
            end
        end
    end

    // run limit
    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_blocks.size());
            $display("twofish_block_cipher_core_top_tb failed");
            $finish;
        end
    end

endmodule
